@@ hdl/dlpd_pkg.sv @@
// ---------------------------------------------------------------------------
// dlpd_pkg : shared types and constants for the length-prefix deframer
// Request formats, per-stream context layout and result codes.
// ---------------------------------------------------------------------------
package dlpd_pkg;

    localparam int STREAMS_DEFAULT = 16;

    localparam logic [15:0] MIN_LEN_RESET = 16'd12;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [3:0] stream_slot;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [3:0]  out_slot;
        logic        kind;
        logic [7:0]  msg_byte;
        logic        first_mark;
        logic        last_mark;
        logic [15:0] frame_len;
    } out_t;

    // Per-stream framing context as held in the context RAM
    typedef struct packed {
        phase_t      phase;
        logic [15:0] msg_length;
        logic [15:0] byte_position;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{phase: PH_LEN_HI, msg_length: 16'd0, byte_position: 16'd0};

    typedef struct packed {
        logic wr_en;
        logic res_valid;
    } step_ctl_t;

endpackage

@@ hdl/dns_length_prefix_deframer_top.sv @@
// ---------------------------------------------------------------------------
// dns_length_prefix_deframer_top : per-stream length-prefix deframer
// Strips 2-byte big-endian length prefixes from interleaved byte streams
// and marks message boundaries.
// ---------------------------------------------------------------------------
// The block takes one byte request per clock cycle, each tagged with a
// stream slot, and gives at most one result per byte through the output
// register. Every slot keeps its framing context (phase, length,
// position) in one context RAM: a byte reads its slot's entry in the cycle
// it is taken, and the execute stage computes and writes back the update
// while the next byte's read is under way. A byte that follows one of the
// same slot takes the just-written context from a one-entry bypass, so the
// sustained rate is one byte per cycle for any mix of slots. The byte input
// stalls only while a result is pending in the execute stage, the output
// register is full and the output side is stalling. Slot entries carry valid
// bits cleared by reset, so no clearing pass is needed after reset; a slot
// number at or above STREAMS is taken and dropped. Prefix bytes and zero
// lengths give no result; a nonzero length below min_msg_len gives one
// error result and halts that slot until reset. Write min_msg_len only while
// no byte is in flight.
// ---------------------------------------------------------------------------
module dns_length_prefix_deframer_top #(
    parameter int STREAMS = dlpd_pkg::STREAMS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,

    input  logic           byte_valid,
    output logic           byte_stall,
    input  dlpd_pkg::in_t  byte_req,

    output logic           result_valid,
    input  logic           result_stall,
    output dlpd_pkg::out_t result_req,

    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);

    import dlpd_pkg::*;

    localparam int AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    // Configuration
    logic [15:0]    min_msg_len_reg;

    // Accept / read stage
    logic           accept;
    logic           in_range;
    logic [AW+3:0]  slot_wide;
    logic [AW-1:0]  rd_addr;
    logic [$bits(ctx_t)-1:0] rd_data;

    // Execute stage
    logic           s1_valid_reg;
    logic           s1_valid_next;
    in_t            s1_req_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic           s1_adv;
    ctx_t           ctx_cur;
    ctx_t           ctx_new;
    step_ctl_t      ctl;
    out_t           res;
    logic           wr_en;

    // Entry valid bits and write-back bypass
    logic [STREAMS-1:0] ent_valid_reg;
    logic           fwd_valid_reg;
    logic [AW-1:0]  fwd_addr_reg;
    ctx_t           fwd_ctx_reg;

    // Output register
    logic           result_valid_reg;
    out_t           result_req_reg;

    // ---------------------------------------------------------------------
    // Accept and read
    // ---------------------------------------------------------------------
    assign accept    = byte_valid && !byte_stall;
    assign in_range  = (32'(byte_req.stream_slot) < STREAMS);
    assign slot_wide = (AW + 4)'(byte_req.stream_slot);
    assign rd_addr   = slot_wide[AW-1:0];

    // Out-of-range slots are taken and dropped here
    assign s1_valid_next = accept ? in_range : (s1_valid_reg && !s1_adv);

    dlpd_ram #(
        .WIDTH ($bits(ctx_t)),
        .DEPTH (STREAMS),
        .AW    (AW)
    ) u_ctx_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (ctx_new),
        .rd_en   (accept && in_range),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------------
    // Execute: pick the freshest context, update, write back
    // ---------------------------------------------------------------------
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            // written at the same edge as the read: take the bypass
            ctx_cur = fwd_ctx_reg;
        end
        else if (ent_valid_reg[s1_addr_reg])
        begin
            ctx_cur = ctx_t'(rd_data);
        end
        else
        begin
            ctx_cur = CTX_RESET;
        end
    end

    dlpd_step u_step (
        .ctx_cur (ctx_cur),
        .req     (s1_req_reg),
        .min_len (min_msg_len_reg),
        .ctx_new (ctx_new),
        .ctl     (ctl),
        .res     (res)
    );

    // Hold the execute stage only when its result has nowhere to go
    assign s1_adv     = s1_valid_reg &&
                        (!ctl.res_valid || !result_valid_reg || !result_stall);
    assign byte_stall = s1_valid_reg && !s1_adv;
    assign wr_en      = s1_adv && ctl.wr_en;

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_msg_len_reg  <= MIN_LEN_RESET;
            s1_valid_reg     <= 1'b0;
            ent_valid_reg    <= '0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_msg_len_reg <= cfg_wdata;
            end

            s1_valid_reg <= s1_valid_next;

            if (wr_en)
            begin
                ent_valid_reg[s1_addr_reg] <= 1'b1;
                fwd_valid_reg              <= 1'b1;
            end

            if (s1_adv && ctl.res_valid)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= byte_req;
            s1_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_ctx_reg  <= ctx_new;
        end
        if (s1_adv && ctl.res_valid)
        begin
            result_req_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_req   = result_req_reg;

`ifndef NO_ASSERTIONS
    // Error results never carry payload or boundary marks
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_req.kind == KIND_ERROR)) |->
            ((result_req.msg_byte == 8'd0) && !result_req.first_mark &&
             !result_req.last_mark))
    else $error("error result carries payload or marks");

    // A one-byte message is first and last at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_req.kind == KIND_BYTE) && result_req.first_mark &&
         (result_req.frame_len == 16'd1)) |-> result_req.last_mark)
    else $error("one-byte message without last mark");

    // Input stalls only with a full execute stage behind a blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (s1_valid_reg && result_valid && result_stall))
    else $error("byte input stalled without back-pressure");

    // The execute stage holds an item only if one was taken or held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(accept))
    else $error("execute stage filled without an accepted byte");
`endif

endmodule

@@ hdl/dlpd_ram.sv @@
// ---------------------------------------------------------------------------
// dlpd_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old data
// on a same-address collision.
// ---------------------------------------------------------------------------
module dlpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/dlpd_step.sv @@
// ---------------------------------------------------------------------------
// dlpd_step : framing update for one received byte
// Take the current stream context and the byte, give the new context,
// whether to write it back, and the result, if any.
// ---------------------------------------------------------------------------
module dlpd_step (
    input  dlpd_pkg::ctx_t      ctx_cur,
    input  dlpd_pkg::in_t       req,
    input  logic [15:0]         min_len,
    output dlpd_pkg::ctx_t      ctx_new,
    output dlpd_pkg::step_ctl_t ctl,
    output dlpd_pkg::out_t      res
);

    import dlpd_pkg::*;

    logic [15:0] len_full;
    logic [16:0] pos_inc;
    logic        last;

    assign len_full = {ctx_cur.msg_length[7:0], req.data_byte};
    assign pos_inc  = {1'b0, ctx_cur.byte_position} + 17'd1;
    assign last     = (pos_inc >= {1'b0, ctx_cur.msg_length});

    always_comb
    begin
        ctx_new        = ctx_cur;
        ctl.wr_en      = 1'b0;
        ctl.res_valid  = 1'b0;
        res.out_slot   = req.stream_slot;
        res.kind       = KIND_BYTE;
        res.msg_byte   = 8'd0;
        res.first_mark = 1'b0;
        res.last_mark  = 1'b0;
        res.frame_len  = ctx_cur.msg_length;

        case (ctx_cur.phase)
            PH_LEN_HI:
            begin
                ctx_new.msg_length = {8'd0, req.data_byte};
                ctx_new.phase      = PH_LEN_LO;
                ctl.wr_en          = 1'b1;
            end
            PH_LEN_LO:
            begin
                ctx_new.msg_length    = len_full;
                ctx_new.byte_position = 16'd0;
                ctl.wr_en             = 1'b1;
                if (len_full == 16'd0)
                begin
                    ctx_new.phase = PH_LEN_HI;
                end
                else if (len_full < min_len)
                begin
                    // short length: report once and halt the stream
                    ctx_new.phase = PH_HALT;
                    ctl.res_valid = 1'b1;
                    res.kind      = KIND_ERROR;
                    res.frame_len = len_full;
                end
                else
                begin
                    ctx_new.phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                ctl.wr_en      = 1'b1;
                ctl.res_valid  = 1'b1;
                res.msg_byte   = req.data_byte;
                res.first_mark = (ctx_cur.byte_position == 16'd0);
                res.last_mark  = last;
                if (last)
                begin
                    ctx_new.byte_position = 16'd0;
                    ctx_new.phase         = PH_LEN_HI;
                end
                else
                begin
                    ctx_new.byte_position = pos_inc[15:0];
                end
            end
            PH_HALT:
            begin
                // drop everything until reset
                ctl.wr_en = 1'b0;
            end
            default:
            begin
                ctl.wr_en = 1'b0;
            end
        endcase
    end

endmodule
